>>> rtl/lfpd_pkg.sv
// Types and constants shared by the line-follower PID drive block.
// No dependencies; the top level imports this package.
package lfpd_pkg;

    localparam int LINE_CENTER = 3500;
    localparam int SUM_LIMIT   = 10000;
    localparam int POS_MAX     = 7000;
    localparam int DRIVE_MAX   = 255;

    // floor(p / LINE_CENTER) == (p * DIV_RECIP) >> DIV_SHIFT, exact for p below 2^20
    localparam int DIV_SHIFT = 31;
    localparam longint unsigned DIV_NUM = 64'd1 << DIV_SHIFT;
    localparam logic [19:0] DIV_RECIP = 20'((DIV_NUM + LINE_CENTER - 1) / LINE_CENTER);

    typedef logic [12:0]        pos_t;
    typedef logic signed [8:0]  drive_t;
    typedef logic [2:0]         cfg_addr_t;
    typedef logic [15:0]        cfg_data_t;

    typedef logic signed [12:0] err_t;
    typedef logic signed [13:0] der_t;
    typedef logic signed [14:0] sum_t;
    typedef logic [11:0]        mag_t;
    typedef logic signed [31:0] pid_t;

    typedef enum logic [2:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_BASE_DRIVE = 3'd3,
        CFG_MIN_DRIVE  = 3'd4,
        CFG_SPIN_LIMIT = 3'd5
    } cfg_reg_t;

endpackage

>>> rtl/line_follow_pid_drive.sv
// Line-follower PID controller with differential wheel drive, five register levels.
// Depends on lfpd_pkg for types, register codes and constants.
//
// Usage:
//   Sample channel (sample_valid / sample_stall / line_pos) takes one sensor
//   position per transaction; drive channel (drive_valid / drive_stall)
//   returns left_drive, right_drive and spin_active for each sample, in order.
//   A transaction completes on a clock edge with valid high and stall low.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   gain, speed and spin registers by index; cfg_ready is always high and
//   writes to unused indexes are dropped. Write only while the block is idle.
//   Throughput: one sample per cycle while the drive side does not stall, set
//   by the four-stage pipeline (error/integral update, products, PID sum and
//   base division, wheel mixing and limits), each stage with its own valid bit.
//   Each result passes the stage registers in order into the output register.
//   When the receiver stalls, the output holds and stages fill in turn; the
//   sample side stalls only once every stage holds a transaction.
//   Reset: restores register defaults, clears integral and previous error,
//   and empties the pipeline.
module line_follow_pid_drive (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  lfpd_pkg::pos_t      line_pos,
    output logic                drive_valid,
    input  logic                drive_stall,
    output lfpd_pkg::drive_t    left_drive,
    output lfpd_pkg::drive_t    right_drive,
    output logic                spin_active,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  lfpd_pkg::cfg_addr_t cfg_index,
    input  lfpd_pkg::cfg_data_t cfg_data
);
    import lfpd_pkg::*;

    localparam logic signed [15:0] SUM_HI = 16'(SUM_LIMIT);
    localparam logic signed [15:0] SUM_LO = -16'(SUM_LIMIT);

    // configuration registers
    logic [15:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [7:0]  base_drive_reg, min_drive_reg;
    logic [11:0] spin_limit_reg;

    // controller state
    err_t prev_err_reg;
    sum_t err_sum_reg;

    // pipeline
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    pos_t s1_pos_reg;
    err_t s2_err_reg;
    sum_t s2_sum_reg;
    der_t s2_der_reg;
    mag_t s2_mag_reg;
    logic signed [28:0] s3_prop_reg;
    logic signed [30:0] s3_integ_reg;
    logic signed [29:0] s3_deriv_reg;
    logic [19:0] s3_scaled_reg;
    logic s3_spin_reg, s3_spin_right_reg;
    pid_t s4_pid_reg;
    logic [7:0] s4_base_reg;
    logic s4_spin_reg, s4_spin_right_reg;
    drive_t left_reg, right_reg;
    logic spin_reg;

    logic take_out, adv4, take4, adv3, take3, adv2, take2, adv1, take1, accept;

    // stage 1 signals
    pos_t pos_c;
    logic signed [13:0] err_w;
    err_t err_next;
    logic signed [15:0] sum_w;
    sum_t err_sum_next;
    der_t der_next;
    mag_t mag_next;

    // stage 2 signals
    logic signed [28:0] prop_next;
    logic signed [30:0] integ_next;
    logic signed [29:0] deriv_next;
    logic [11:0] span;
    logic [19:0] scaled_next;
    logic signed [13:0] err_x, lim_x;
    logic spin_left, spin_right;

    // stage 3 signals
    pid_t pid_next;
    logic [39:0] quot_prod;
    logic [7:0] base_next;

    // stage 4 signals
    logic signed [32:0] base_x, pid_x;
    logic signed [24:0] left_raw, right_raw;
    drive_t left_lim, right_lim, left_next, right_next;

    function automatic logic signed [24:0] div256(input logic signed [32:0] v);
        logic signed [32:0] adj;
        // bias negatives so the shift truncates toward zero
        adj = v[32] ? v + 33'sd255 : v;
        return adj[32:8];
    endfunction

    function automatic drive_t lift_clamp(input logic signed [24:0] v, input logic [7:0] lo);
        logic signed [24:0] lo_s;
        drive_t r;
        lo_s = signed'({17'b0, lo});
        priority if (v > 25'sd255)
        begin
            r = 9'sd255;
        end
        else if (v < -25'sd255)
        begin
            r = -9'sd255;
        end
        else if (v > 25'sd0 && v < lo_s)
        begin
            r = signed'({1'b0, lo});
        end
        else if (v < 25'sd0 && v > -lo_s)
        begin
            r = -signed'({1'b0, lo});
        end
        else
        begin
            r = v[8:0];
        end
        return r;
    endfunction

    // handshake chain: a stage takes a new transaction when empty or draining
    always_comb
    begin
        take_out = !out_valid_reg || !drive_stall;
        adv4     = s4_valid_reg && take_out;
        take4    = !s4_valid_reg || adv4;
        adv3     = s3_valid_reg && take4;
        take3    = !s3_valid_reg || adv3;
        adv2     = s2_valid_reg && take3;
        take2    = !s2_valid_reg || adv2;
        adv1     = s1_valid_reg && take2;
        take1    = !s1_valid_reg || adv1;
        accept   = sample_valid && take1;
    end

    assign sample_stall = !take1;
    assign drive_valid  = out_valid_reg;
    assign left_drive   = left_reg;
    assign right_drive  = right_reg;
    assign spin_active  = spin_reg;
    assign cfg_ready    = 1'b1;

    // stage 1: error, integral and derivative
    always_comb
    begin
        pos_c    = (s1_pos_reg > 13'(POS_MAX)) ? 13'(POS_MAX) : s1_pos_reg;
        err_w    = signed'({1'b0, pos_c}) - 14'(LINE_CENTER);
        err_next = err_w[12:0];
        sum_w    = 16'(err_sum_reg) + 16'(err_next);
        priority if (err_next == 13'sd0)
        begin
            err_sum_next = '0;
        end
        else if (sum_w > SUM_HI)
        begin
            err_sum_next = SUM_HI[14:0];
        end
        else if (sum_w < SUM_LO)
        begin
            err_sum_next = SUM_LO[14:0];
        end
        else
        begin
            err_sum_next = sum_w[14:0];
        end
        der_next = 14'(err_next) - 14'(prev_err_reg);
        mag_next = err_w[13] ? 12'(-err_w) : 12'(err_w);
    end

    // stage 2: gain products, base scaling product, spin decision
    always_comb
    begin
        prop_next   = 29'(signed'({1'b0, gain_prop_reg})) * 29'(s2_err_reg);
        integ_next  = 31'(signed'({1'b0, gain_integ_reg})) * 31'(s2_sum_reg);
        deriv_next  = 30'(signed'({1'b0, gain_deriv_reg})) * 30'(s2_der_reg);
        span        = 12'(LINE_CENTER) - s2_mag_reg;
        scaled_next = 20'(base_drive_reg) * 20'(span);
        err_x       = 14'(s2_err_reg);
        lim_x       = signed'({2'b0, spin_limit_reg});
        spin_left   = err_x <= -lim_x;
        spin_right  = err_x >= lim_x;
    end

    // stage 3: PID sum and division of the base product by the line center
    always_comb
    begin
        pid_next  = 32'(s3_prop_reg) + 32'(s3_integ_reg) + 32'(s3_deriv_reg);
        quot_prod = 40'(s3_scaled_reg) * 40'(DIV_RECIP);
        base_next = quot_prod[DIV_SHIFT +: 8];
    end

    // stage 4: wheel mixing, truncation, deadband lift, clamp, spin override
    always_comb
    begin
        base_x    = signed'({17'b0, s4_base_reg, 8'b0});
        pid_x     = 33'(s4_pid_reg);
        left_raw  = div256(base_x + pid_x);
        right_raw = div256(base_x - pid_x);
        left_lim  = lift_clamp(left_raw, min_drive_reg);
        right_lim = lift_clamp(right_raw, min_drive_reg);
        priority if (s4_spin_reg && s4_spin_right_reg)
        begin
            left_next  = 9'(DRIVE_MAX);
            right_next = -9'(DRIVE_MAX);
        end
        else if (s4_spin_reg)
        begin
            left_next  = -9'(DRIVE_MAX);
            right_next = 9'(DRIVE_MAX);
        end
        else
        begin
            left_next  = left_lim;
            right_next = right_lim;
        end
    end

    // control: valid bits, controller state, configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            err_sum_reg    <= '0;
            gain_prop_reg  <= 16'd51;
            gain_integ_reg <= 16'd0;
            gain_deriv_reg <= 16'd1024;
            base_drive_reg <= 8'd220;
            min_drive_reg  <= 8'd60;
            spin_limit_reg <= 12'd3000;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !adv1);
            s2_valid_reg  <= adv1 || (s2_valid_reg && !adv2);
            s3_valid_reg  <= adv2 || (s3_valid_reg && !adv3);
            s4_valid_reg  <= adv3 || (s4_valid_reg && !adv4);
            out_valid_reg <= adv4 || (out_valid_reg && !take_out);
            if (adv1)
            begin
                prev_err_reg <= err_next;
                err_sum_reg  <= err_sum_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                    CFG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                    CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                    CFG_BASE_DRIVE: base_drive_reg <= cfg_data[7:0];
                    CFG_MIN_DRIVE:  min_drive_reg  <= cfg_data[7:0];
                    CFG_SPIN_LIMIT: spin_limit_reg <= cfg_data[11:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers, loaded as each stage advances
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= line_pos;
        end
        if (adv1)
        begin
            s2_err_reg <= err_next;
            s2_sum_reg <= err_sum_next;
            s2_der_reg <= der_next;
            s2_mag_reg <= mag_next;
        end
        if (adv2)
        begin
            s3_prop_reg       <= prop_next;
            s3_integ_reg      <= integ_next;
            s3_deriv_reg      <= deriv_next;
            s3_scaled_reg     <= scaled_next;
            s3_spin_reg       <= spin_left || spin_right;
            s3_spin_right_reg <= spin_right;
        end
        if (adv3)
        begin
            s4_pid_reg        <= pid_next;
            s4_base_reg       <= base_next;
            s4_spin_reg       <= s3_spin_reg;
            s4_spin_right_reg <= s3_spin_right_reg;
        end
        if (adv4)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            spin_reg  <= s4_spin_reg;
        end
    end

endmodule

>>> tb/drive_checker.sv
`timescale 1ns / 100ps
// Checker for line_follow_pid_drive: watches the sample, drive and register write channels,
// predicts each wheel command from its own model of the controller, and counts mismatches.
// Depends on lfpd_pkg for port types, register codes and controller constants.
module drive_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                sample_stall,
    input  lfpd_pkg::pos_t      line_pos,
    input  logic                drive_valid,
    input  logic                drive_stall,
    input  lfpd_pkg::drive_t    left_drive,
    input  lfpd_pkg::drive_t    right_drive,
    input  logic                spin_active,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  lfpd_pkg::cfg_addr_t cfg_index,
    input  lfpd_pkg::cfg_data_t cfg_data,
    output int                  mismatches,
    output int                  pending
);
    import lfpd_pkg::*;

    typedef struct {
        drive_t left;
        drive_t right;
        logic   spin;
    } wheel_cmd_t;

    localparam longint KP_RESET    = 51;
    localparam longint KI_RESET    = 0;
    localparam longint KD_RESET    = 1024;
    localparam longint BASE_RESET  = 220;
    localparam longint FLOOR_RESET = 60;
    localparam longint SPIN_RESET  = 3000;

    longint kp, ki, kd, base_speed, floor_mag, spin_thr;
    longint last_err, err_integ;
    wheel_cmd_t expected_cmds[$];
    int fail_count = 0;
    int queued = 0;

    assign mismatches = fail_count;
    assign pending    = queued;

    function automatic longint lift_and_limit(input longint v, input longint lo_mag);
        if (v > 0 && v < lo_mag)
            v = lo_mag;
        if (v < 0 && v > -lo_mag)
            v = -lo_mag;
        if (v > DRIVE_MAX)
            v = DRIVE_MAX;
        if (v < -DRIVE_MAX)
            v = -DRIVE_MAX;
        return v;
    endfunction

    // Advance the controller state by one sample and return the wheel command it yields.
    function automatic wheel_cmd_t steer(input pos_t raw);
        longint pos, err, der, pid, mag, base, left, right;
        wheel_cmd_t cmd;
        pos = longint'(raw);
        if (pos > POS_MAX)
            pos = POS_MAX;
        err = pos - LINE_CENTER;
        if (err == 0)
            err_integ = 0;
        else
        begin
            err_integ += err;
            if (err_integ > SUM_LIMIT)
                err_integ = SUM_LIMIT;
            if (err_integ < -SUM_LIMIT)
                err_integ = -SUM_LIMIT;
        end
        der = err - last_err;
        last_err = err;
        pid = kp * err + ki * err_integ + kd * der;
        mag = (err < 0) ? -err : err;
        base = (mag >= LINE_CENTER) ? 0 : (base_speed * (LINE_CENTER - mag)) / LINE_CENTER;
        // signed division truncates toward zero
        left  = (base * 256 + pid) / 256;
        right = (base * 256 - pid) / 256;
        cmd.spin = 1'b0;
        if (err <= -spin_thr)
        begin
            left = -DRIVE_MAX;
            right = DRIVE_MAX;
            cmd.spin = 1'b1;
        end
        // spin right is tested last so it wins when the threshold is zero
        if (err >= spin_thr)
        begin
            left = DRIVE_MAX;
            right = -DRIVE_MAX;
            cmd.spin = 1'b1;
        end
        left  = lift_and_limit(left, floor_mag);
        right = lift_and_limit(right, floor_mag);
        cmd.left  = drive_t'(left[8:0]);
        cmd.right = drive_t'(right[8:0]);
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_cmd_t exp_cmd;
        if (!rst_n)
        begin
            kp = KP_RESET;
            ki = KI_RESET;
            kd = KD_RESET;
            base_speed = BASE_RESET;
            floor_mag = FLOOR_RESET;
            spin_thr = SPIN_RESET;
            last_err = 0;
            err_integ = 0;
            expected_cmds.delete();
            queued = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_PROP:  kp = longint'(cfg_data);
                    CFG_GAIN_INTEG: ki = longint'(cfg_data);
                    CFG_GAIN_DERIV: kd = longint'(cfg_data);
                    CFG_BASE_DRIVE: base_speed = longint'(cfg_data[7:0]);
                    CFG_MIN_DRIVE:  floor_mag = longint'(cfg_data[7:0]);
                    CFG_SPIN_LIMIT: spin_thr = longint'(cfg_data[11:0]);
                    default: ;
                endcase
            end
            if (drive_valid && !drive_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("checker: unexpected drive left=%0d right=%0d spin=%0b",
                                 left_drive, right_drive, spin_active);
                    fail_count++;
                end
                else
                begin
                    exp_cmd = expected_cmds.pop_front();
                    if (exp_cmd.left !== left_drive || exp_cmd.right !== right_drive ||
                        exp_cmd.spin !== spin_active)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("checker: mismatch expected left=%0d right=%0d spin=%0b,",
                                   exp_cmd.left, exp_cmd.right, exp_cmd.spin);
                            $display(" got left=%0d right=%0d spin=%0b",
                                     left_drive, right_drive, spin_active);
                        end
                        fail_count++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                expected_cmds.push_back(steer(line_pos));
            queued = expected_cmds.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the line_follow_pid_drive testbench: clock, reset, sample and register stimulus,
// and the drive-side stall pattern. Depends on lfpd_pkg, the block and drive_checker.
module testbench;
    import lfpd_pkg::*;

    localparam int        RANDOM_PER_PHASE = 215;
    localparam int        PHASES           = 9;
    localparam int        HOLD_CYCLES      = 60;
    localparam int        LIMIT_CYCLES     = 400000;
    localparam cfg_addr_t UNUSED_IDX_LO    = 3'd6;
    localparam cfg_addr_t UNUSED_IDX_HI    = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      sample_valid;
    logic      sample_stall;
    pos_t      line_pos;
    logic      drive_valid;
    logic      drive_stall;
    drive_t    left_drive;
    drive_t    right_drive;
    logic      spin_active;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_addr_t cfg_index;
    cfg_data_t cfg_data;

    int   mismatches;
    int   pending;
    int   cycles = 0;
    int   walk_pos = 3500;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;

    line_follow_pid_drive i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .line_pos     (line_pos),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .spin_active  (spin_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    drive_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .line_pos     (line_pos),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .spin_active  (spin_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Called and returns at a falling edge; valid stays high across back-to-back samples.
    task automatic send_sample(input pos_t pos);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        line_pos <= pos;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write of a batch.
    task automatic write_reg(input cfg_addr_t idx, input cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic pos_t pick_pos();
        case ($urandom_range(0, 9))
            0: return pos_t'($urandom_range(0, 8191));
            1: return pos_t'(LINE_CENTER);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return pos_t'(0);
                    1: return pos_t'(POS_MAX);
                    2: return pos_t'(8191);
                    default: return pos_t'($urandom_range(POS_MAX + 1, 8191));
                endcase
            end
            3:
            begin
                walk_pos = $urandom_range(0, POS_MAX);
                return pos_t'(walk_pos);
            end
            default:
            begin
                // drift around the line so the integral and derivative see real tracks
                walk_pos += $urandom_range(0, 200) - 100;
                if (walk_pos < 0)
                    walk_pos = 0;
                if (walk_pos > POS_MAX)
                    walk_pos = POS_MAX;
                return pos_t'(walk_pos);
            end
        endcase
    endfunction

    function automatic cfg_data_t pick_gain();
        case ($urandom_range(0, 7))
            0: return cfg_data_t'($urandom_range(0, 65535));
            1: return cfg_data_t'(0);
            default: return cfg_data_t'($urandom_range(0, 600));
        endcase
    endfunction

    task automatic program_phase(input int phase);
        case (phase)
            1:
            begin
                write_reg(CFG_GAIN_PROP, 16'h0000);
                write_reg(CFG_GAIN_INTEG, 16'h0000);
                write_reg(CFG_GAIN_DERIV, 16'h0000);
                write_reg(CFG_BASE_DRIVE, 16'h0000);
                write_reg(CFG_MIN_DRIVE, 16'h0000);
                write_reg(CFG_SPIN_LIMIT, 16'h0000);
            end
            2:
            begin
                write_reg(CFG_GAIN_PROP, 16'hFFFF);
                write_reg(CFG_GAIN_INTEG, 16'hFFFF);
                write_reg(CFG_GAIN_DERIV, 16'hFFFF);
                write_reg(CFG_BASE_DRIVE, 16'hFFFF);
                write_reg(CFG_MIN_DRIVE, 16'hFFFF);
                write_reg(CFG_SPIN_LIMIT, 16'hFFFF);
                // unused indexes must not disturb anything
                write_reg(UNUSED_IDX_LO, cfg_data_t'($urandom_range(0, 65535)));
                write_reg(UNUSED_IDX_HI, 16'h0000);
            end
            3:
            begin
                write_reg(CFG_GAIN_PROP, pick_gain());
                write_reg(CFG_GAIN_INTEG, cfg_data_t'($urandom_range(0, 8)));
                write_reg(CFG_GAIN_DERIV, pick_gain());
                write_reg(CFG_BASE_DRIVE, 16'h00FF);
                write_reg(CFG_MIN_DRIVE, 16'h0000);
                write_reg(CFG_SPIN_LIMIT, cfg_data_t'(LINE_CENTER));
            end
            default:
            begin
                write_reg(CFG_GAIN_PROP, pick_gain());
                write_reg(CFG_GAIN_INTEG, cfg_data_t'($urandom_range(0, 20)));
                write_reg(CFG_GAIN_DERIV, pick_gain());
                write_reg(CFG_BASE_DRIVE, cfg_data_t'($urandom_range(0, 65535)));
                write_reg(CFG_MIN_DRIVE,
                          cfg_data_t'({$urandom_range(0, 255), 8'($urandom_range(0, 100))}));
                if ($urandom_range(0, 4) == 0)
                    write_reg(CFG_SPIN_LIMIT, cfg_data_t'($urandom_range(3501, 65535)));
                else
                    write_reg(CFG_SPIN_LIMIT, cfg_data_t'($urandom_range(0, LINE_CENTER)));
                if ($urandom_range(0, 1) == 0)
                    write_reg(UNUSED_IDX_HI, cfg_data_t'($urandom_range(0, 65535)));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Drive side: random stall per result, plus one long hold-off on request.
    initial
    begin
        int stall_n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall_n = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_req)
            begin
                stall_n += HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall_n > 0)
            begin
                drive_stall <= 1'b1;
                repeat (stall_n) @(negedge clk);
            end
            drive_stall <= 1'b0;
            do
                @(posedge clk);
            while (!drive_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        pos_t directed[$];
        rst_n = 1'b0;
        sample_valid = 1'b0;
        line_pos = '0;
        drive_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: centered, extremes, saturation, spin edges, deadband, integral.
        directed = '{13'd3500, 13'd3500, 13'd0, 13'd7000, 13'd7001, 13'd8191, 13'd3501,
                     13'd3499, 13'd500, 13'd6500, 13'd501, 13'd6499, 13'd3560, 13'd3440,
                     13'd3520, 13'd4000, 13'd4000, 13'd4000, 13'd7000, 13'd7000, 13'd7000,
                     13'd3500, 13'd0, 13'd4096, 13'd2730};
        foreach (directed[i])
            send_sample(directed[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                program_phase(phase);
            end
            // zero error with a zero threshold resolves to a right spin
            if (phase == 1)
            begin
                send_sample(pos_t'(LINE_CENTER));
                send_sample(pos_t'(LINE_CENTER));
            end
            if (phase == 2)
                repeat (4) send_sample(pos_t'(POS_MAX));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if (phase == 5 && n == 60)
                begin
                    idle_on = 1'b0;
                    hold_req = 1'b1;
                end
                send_sample(pick_pos());
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
